// File: src/lc3_pkg.sv
// Shared types, constants and helpers for the LC-3 instruction step core.
package lc3_pkg;

  // Memory address width and depth
  localparam int ADDR_BITS = 16;
  localparam int MEM_WORDS = 1 << ADDR_BITS;

  // Program counter after reset
  localparam logic [15:0] START_PC_RST = 16'h3000;

  // One-hot condition flags
  localparam logic [2:0] FLAG_P = 3'b001;
  localparam logic [2:0] FLAG_Z = 3'b010;
  localparam logic [2:0] FLAG_N = 3'b100;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EXEC  = 2'd2,
    OP_NONE  = 2'd3
  } item_op_t;

  // Instruction opcodes
  typedef enum logic [3:0] {
    OPC_BR   = 4'h0,
    OPC_ADD  = 4'h1,
    OPC_LD   = 4'h2,
    OPC_ST   = 4'h3,
    OPC_JSR  = 4'h4,
    OPC_AND  = 4'h5,
    OPC_LDR  = 4'h6,
    OPC_STR  = 4'h7,
    OPC_RTI  = 4'h8,
    OPC_NOT  = 4'h9,
    OPC_LDI  = 4'hA,
    OPC_STI  = 4'hB,
    OPC_JMP  = 4'hC,
    OPC_RES  = 4'hD,
    OPC_LEA  = 4'hE,
    OPC_TRAP = 4'hF
  } opcode_t;

  // Shared ALU operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_AND,
    ALU_NOT
  } alu_op_t;

  // Condition flags for a result word
  function automatic logic [2:0] cc_of(input logic [15:0] w);
    logic [2:0] f;
    if (w == 16'h0000) begin
      f = FLAG_Z;
    end else if (w[15]) begin
      f = FLAG_N;
    end else begin
      f = FLAG_P;
    end
    return f;
  endfunction

endpackage

// File: src/lc3_ram.sv
// Generic single-port RAM with registered read data.
module lc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, read every cycle (old data on a write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/lc3_alu.sv
// Shared 16-bit ALU: adder for all address and data sums, plus AND and NOT.
module lc3_alu import lc3_pkg::*; (
  input  alu_op_t     op,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [15:0] y
);

  // Select the operation
  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_AND: y = a & b;
      ALU_NOT: y = ~a;
      default: y = a + b;
    endcase
  end

endmodule

// File: src/lc3_instruction_step.sv
// Top level of the LC-3 instruction step core: sequencer, register file and state.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+----------------------------
//  input   | in_op, in_address, in_write_data             | start high while busy low
//  result  | out_pc, out_cond_flags, out_halted,          | out_valid for one cycle,
//          | out_read_data                                | always taken
//  config  | cfg_start_pc                                 | cfg_valid and cfg_ready
//
// A write, halted or unused item returns its result straight from idle, a read
// item after ST_RDWAIT. An execute item steps through fetch, decode, operand read,
// execute, then for LD, LDR, LDI, STI and TRAP further states on the single memory port.
// An RTI or reserved opcode stops after decode.
// After reset the core loads the PC in ST_INIT before it accepts an item.
// The memory has no reset; the register file, PC, flags and halt flag do.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lc3_instruction_step import lc3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_op,
  input  logic [15:0]          in_address,
  input  logic [15:0]          in_write_data,
  output logic                 out_valid,
  output logic [15:0]          out_pc,
  output logic [2:0]           out_cond_flags,
  output logic                 out_halted,
  output logic [15:0]          out_read_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_start_pc
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RDWAIT,
    ST_FETCH,
    ST_DECODE,
    ST_OPND,
    ST_EXEC,
    ST_INDR,
    ST_LDWB,
    ST_STIW,
    ST_TRAPW
  } state_t;

  state_t               state_r;
  logic [15:0]          pc_r;
  logic [2:0]           cc_r;
  logic                 halt_r;
  logic [15:0]          start_pc_r;
  logic                 out_valid_r;
  logic [15:0]          read_data_r;
  logic [15:0]          ir_r;
  logic [15:0]          a_r;
  logic [15:0]          b_r;
  logic [15:0]          rf_r [8];

  logic [2:0]           rf_raddr;
  logic [15:0]          rf_rdata;
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [15:0]          ram_wdata;
  logic [15:0]          ram_rdata;
  alu_op_t              alu_op;
  logic [15:0]          alu_a;
  logic [15:0]          alu_b;
  logic [15:0]          alu_y;
  opcode_t              opc;
  opcode_t              fetched_opc;
  item_op_t             item_op;
  logic [2:0]           dr;
  logic [15:0]          sext5;
  logic [15:0]          sext6;
  logic [15:0]          sext9;
  logic [15:0]          sext11;
  logic [15:0]          src2;

  // Decode fields of the held instruction
  assign opc         = opcode_t'(ir_r[15:12]);
  assign fetched_opc = opcode_t'(ram_rdata[15:12]);
  assign item_op     = item_op_t'(in_op);
  assign dr          = ir_r[11:9];
  assign sext5       = {{11{ir_r[4]}}, ir_r[4:0]};
  assign sext6       = {{10{ir_r[5]}}, ir_r[5:0]};
  assign sext9       = {{7{ir_r[8]}}, ir_r[8:0]};
  assign sext11      = {{5{ir_r[10]}}, ir_r[10:0]};
  assign src2        = ir_r[5] ? sext5 : b_r;

  // Single register file read port
  always_comb begin
    case (state_r)
      ST_DECODE: rf_raddr = ram_rdata[8:6];
      ST_OPND:   rf_raddr = (opc == OPC_ADD || opc == OPC_AND) ? ir_r[2:0] : ir_r[11:9];
      default:   rf_raddr = ir_r[8:6];
    endcase
  end
  assign rf_rdata = rf_r[rf_raddr];

  // Steer the shared ALU
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = pc_r;
    alu_b  = sext9;
    case (state_r)
      ST_FETCH: begin
        alu_b = 16'h0001;
      end
      ST_EXEC: begin
        case (opc)
          OPC_ADD: begin
            alu_a = a_r;
            alu_b = src2;
          end
          OPC_AND: begin
            alu_op = ALU_AND;
            alu_a  = a_r;
            alu_b  = src2;
          end
          OPC_NOT: begin
            alu_op = ALU_NOT;
            alu_a  = a_r;
          end
          OPC_LDR, OPC_STR: begin
            alu_a = a_r;
            alu_b = sext6;
          end
          OPC_JSR: begin
            alu_b = sext11;
          end
          default: begin
            alu_b = sext9;
          end
        endcase
      end
      default: begin
        alu_b = sext9;
      end
    endcase
  end

  lc3_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Steer the memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pc_r[ADDR_BITS-1:0];
    ram_wdata = b_r;
    case (state_r)
      ST_IDLE: begin
        ram_addr  = in_address[ADDR_BITS-1:0];
        ram_wdata = in_write_data;
        ram_we    = start && (item_op == OP_WRITE);
      end
      ST_EXEC: begin
        case (opc)
          OPC_TRAP: ram_addr = ADDR_BITS'(ir_r[7:0]);
          OPC_ST, OPC_STR: begin
            ram_addr = alu_y[ADDR_BITS-1:0];
            ram_we   = 1'b1;
          end
          default: ram_addr = alu_y[ADDR_BITS-1:0];
        endcase
      end
      ST_INDR: begin
        ram_addr = ram_rdata[ADDR_BITS-1:0];
      end
      ST_STIW: begin
        ram_addr = ram_rdata[ADDR_BITS-1:0];
        ram_we   = 1'b1;
      end
      default: begin
        ram_addr = pc_r[ADDR_BITS-1:0];
      end
    endcase
  end

  lc3_ram #(
    .WIDTH (16),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer, architectural state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      pc_r        <= START_PC_RST;
      cc_r        <= FLAG_Z;
      halt_r      <= 1'b0;
      start_pc_r  <= START_PC_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        rf_r[i] <= 16'h0000;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        start_pc_r <= cfg_start_pc;
      end
      case (state_r)
        ST_INIT: begin
          pc_r    <= start_pc_r;
          state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            read_data_r <= 16'h0000;
            case (item_op)
              OP_READ: state_r <= ST_RDWAIT;
              OP_EXEC: begin
                if (halt_r) begin
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= ST_FETCH;
                end
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        ST_RDWAIT: begin
          read_data_r <= ram_rdata;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        ST_FETCH: begin
          pc_r    <= alu_y;
          state_r <= ST_DECODE;
        end
        ST_DECODE: begin
          ir_r <= ram_rdata;
          a_r  <= rf_rdata;
          if (fetched_opc == OPC_RTI || fetched_opc == OPC_RES) begin
            halt_r      <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            state_r <= ST_OPND;
          end
        end
        ST_OPND: begin
          b_r     <= rf_rdata;
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
          case (opc)
            OPC_BR: begin
              if ((ir_r[11:9] & cc_r) != 3'b000) begin
                pc_r <= alu_y;
              end
            end
            OPC_ADD, OPC_AND, OPC_NOT, OPC_LEA: begin
              rf_r[dr] <= alu_y;
              cc_r     <= cc_of(alu_y);
            end
            OPC_LD, OPC_LDR: begin
              out_valid_r <= 1'b0;
              state_r     <= ST_LDWB;
            end
            OPC_LDI: begin
              out_valid_r <= 1'b0;
              state_r     <= ST_INDR;
            end
            OPC_STI: begin
              out_valid_r <= 1'b0;
              state_r     <= ST_STIW;
            end
            OPC_JSR: begin
              rf_r[7] <= pc_r;
              pc_r    <= ir_r[11] ? alu_y : a_r;
            end
            OPC_JMP: begin
              pc_r <= a_r;
            end
            OPC_TRAP: begin
              rf_r[7]     <= pc_r;
              out_valid_r <= 1'b0;
              state_r     <= ST_TRAPW;
            end
            default: begin
              // stores complete on the memory port this cycle
            end
          endcase
        end
        ST_INDR: begin
          state_r <= ST_LDWB;
        end
        ST_LDWB: begin
          rf_r[dr]    <= ram_rdata;
          cc_r        <= cc_of(ram_rdata);
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        ST_STIW: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        ST_TRAPW: begin
          pc_r        <= ram_rdata;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Drive the ports
  assign busy           = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_pc         = pc_r;
  assign out_cond_flags = cc_r;
  assign out_halted     = halt_r;
  assign out_read_data  = read_data_r;

  // Results appear only once the sequencer is back at rest
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_IDLE)
    else $error("result strobe outside idle");

  // An accepted item either starts work or delivers its result next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item made no progress");

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped");

  // Exactly one condition flag is set
  a_cc_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(cc_r))
    else $error("condition flags not one-hot");

endmodule
